/* sv/hcbd_pkg.sv */
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types and constants for the chunked body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

  localparam int HCBD_LEN_BITS    = 32;
  localparam int HCBD_QUEUE_DEPTH = 2;

  localparam logic [7:0] LINE_FEED = 8'h0A;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERR   = 2'd2,
    KIND_TRUNC = 2'd3
  } kind_t;

  // classified input item
  typedef struct packed {
    logic [7:0] data;
    logic       is_end;
    logic       is_ws;
    logic       is_lf;
    logic       is_hex;
    logic [3:0] hex_val;
  } class_t;

  // result item
  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       last;
  } result_t;

endpackage

/* sv/http_chunked_body_decoder.sv */
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// HTTP/1.1 chunked transfer decoder, one body byte per item.
// ----------------------------------------------------------------------------
// Accepts one byte per cycle while not full and yields at most one result
// per byte, so the sustained rate is one item per clock while results are
// popped. A byte passes the classifier and a two-entry queue, then the
// framing state machine, then a two-entry result queue, which registers its
// result. Chunk sizes are hex, up to LEN_BITS bits; a size line with no digit
// or an oversize length gives a size line error at its line feed, and an end
// marker inside a message gives a truncated input result.
module http_chunked_body_decoder
  import hcbd_pkg::*;
#(
  parameter int LEN_BITS = HCBD_LEN_BITS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_end,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte,
  output logic [1:0] out_kind,
  output logic       chunk_last
);

  class_t  cls_in;
  class_t  cls_q;
  logic    cls_empty;
  logic    cls_pop;
  result_t res_in;
  result_t res_q;
  logic    res_push;
  logic    res_full;

  hcbd_front u_front (
    .in_byte (in_byte),
    .in_end  (in_end),
    .cls     (cls_in)
  );

  hcbd_queue #(
    .WIDTH ($bits(class_t)),
    .DEPTH (HCBD_QUEUE_DEPTH)
  ) u_cls_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (cls_in),
    .full    (full),
    .pop     (cls_pop),
    .rd_data (cls_q),
    .empty   (cls_empty)
  );

  hcbd_back #(
    .LEN_BITS (LEN_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cls       (cls_q),
    .cls_empty (cls_empty),
    .cls_pop   (cls_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  hcbd_queue #(
    .WIDTH ($bits(result_t)),
    .DEPTH (HCBD_QUEUE_DEPTH)
  ) u_res_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .pop     (pop),
    .rd_data (res_q),
    .empty   (empty)
  );

  assign out_byte   = res_q.data;
  assign out_kind   = res_q.kind;
  assign chunk_last = res_q.last;

endmodule

/* sv/hcbd_front.sv */
// ----------------------------------------------------------------------------
// hcbd_front
// Classifies each raw body byte: whitespace, line feed, hex digit and value.
// ----------------------------------------------------------------------------
module hcbd_front
  import hcbd_pkg::*;
(
  input  logic [7:0] in_byte,
  input  logic       in_end,
  output class_t     cls
);

  logic       is_dec;
  logic       is_upper;
  logic       is_lower;
  logic [7:0] hex_full;

  always_comb begin
    is_dec   = (in_byte >= 8'h30) && (in_byte <= 8'h39);
    is_upper = (in_byte >= 8'h41) && (in_byte <= 8'h46);
    is_lower = (in_byte >= 8'h61) && (in_byte <= 8'h66);
    if (is_dec) begin
      hex_full = in_byte - 8'h30;
    end else if (is_upper) begin
      hex_full = in_byte - 8'h37;
    end else if (is_lower) begin
      hex_full = in_byte - 8'h57;
    end else begin
      hex_full = 8'h00;
    end

    cls.data    = in_byte;
    cls.is_end  = in_end;
    cls.is_ws   = (in_byte == 8'h20) || ((in_byte >= 8'h09) && (in_byte <= 8'h0D));
    cls.is_lf   = (in_byte == LINE_FEED);
    cls.is_hex  = is_dec || is_upper || is_lower;
    cls.hex_val = hex_full[3:0];
  end

endmodule

/* sv/hcbd_queue.sv */
// ----------------------------------------------------------------------------
// hcbd_queue
// Small first-word-fall-through queue with count-based full and empty.
// ----------------------------------------------------------------------------
module hcbd_queue
  import hcbd_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = HCBD_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* sv/hcbd_back.sv */
// ----------------------------------------------------------------------------
// hcbd_back
// Chunk framing state machine: size line parsing, payload pass, trailer.
// ----------------------------------------------------------------------------
module hcbd_back
  import hcbd_pkg::*;
#(
  parameter int LEN_BITS = HCBD_LEN_BITS
) (
  input  logic    clk,
  input  logic    rst,
  input  class_t  cls,
  input  logic    cls_empty,
  output logic    cls_pop,
  input  logic    res_full,
  output logic    res_push,
  output result_t res
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WS,
    ST_DIGITS,
    ST_EXT,
    ST_DATA,
    ST_TRAILER
  } state_t;

  state_t              state, state_next;
  logic [LEN_BITS-1:0] remaining, remaining_next;
  logic                saw_digit, saw_digit_next;
  logic                size_overflow, size_overflow_next;
  logic                take;
  logic                ovf_hit;
  logic [LEN_BITS-1:0] rem_dec;

  assign take    = !cls_empty && !res_full;
  assign cls_pop = take;
  assign ovf_hit = (remaining[LEN_BITS-1 -: 4] != 4'h0);
  assign rem_dec = remaining - 1'b1;

  always_comb begin
    state_next         = state;
    remaining_next     = remaining;
    saw_digit_next     = saw_digit;
    size_overflow_next = size_overflow;
    res_push           = 1'b0;
    res                = '0;

    if (take) begin
      if (cls.is_end) begin
        if (state != ST_IDLE) begin
          res_push = 1'b1;
          res.kind = KIND_TRUNC;
        end
        state_next         = ST_IDLE;
        remaining_next     = '0;
        saw_digit_next     = 1'b0;
        size_overflow_next = 1'b0;
      end else begin
        unique case (state)
          ST_IDLE, ST_WS: begin
            if (!cls.is_ws) begin
              size_overflow_next = 1'b0;
              if (cls.is_hex) begin
                remaining_next = LEN_BITS'(cls.hex_val);
                saw_digit_next = 1'b1;
                state_next     = ST_DIGITS;
              end else begin
                remaining_next = '0;
                saw_digit_next = 1'b0;
                state_next     = ST_EXT;
              end
            end
          end
          ST_DIGITS, ST_EXT: begin
            if (cls.is_lf) begin
              if (!saw_digit || size_overflow) begin
                res_push           = 1'b1;
                res.kind           = KIND_ERR;
                state_next         = ST_IDLE;
                remaining_next     = '0;
              end else begin
                state_next = (remaining == '0) ? ST_TRAILER : ST_DATA;
              end
              saw_digit_next     = 1'b0;
              size_overflow_next = 1'b0;
            end else if (state == ST_DIGITS) begin
              if (cls.is_hex) begin
                saw_digit_next = 1'b1;
                if (!size_overflow) begin
                  if (ovf_hit) begin
                    size_overflow_next = 1'b1;
                  end else begin
                    remaining_next = {remaining[LEN_BITS-5:0], cls.hex_val};
                  end
                end
              end else begin
                state_next = ST_EXT;
              end
            end
          end
          ST_DATA: begin
            remaining_next = rem_dec;
            res_push       = 1'b1;
            res.data       = cls.data;
            res.kind       = KIND_DATA;
            res.last       = (rem_dec == '0);
            if (rem_dec == '0) begin
              state_next = ST_WS;
            end
          end
          ST_TRAILER: begin
            if (cls.is_lf) begin
              res_push       = 1'b1;
              res.kind       = KIND_END;
              state_next     = ST_IDLE;
              remaining_next = '0;
            end
          end
          default: begin
            state_next         = ST_IDLE;
            remaining_next     = '0;
            saw_digit_next     = 1'b0;
            size_overflow_next = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      remaining     <= '0;
      saw_digit     <= 1'b0;
      size_overflow <= 1'b0;
    end else begin
      state         <= state_next;
      remaining     <= remaining_next;
      saw_digit     <= saw_digit_next;
      size_overflow <= size_overflow_next;
    end
  end

`ifndef SYNTHESIS
  a_data_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_DATA |-> remaining != '0)
    else $error("payload phase with zero length");

  a_push_needs_take: assert property (@(posedge clk) disable iff (rst)
    res_push |-> take)
    else $error("result pushed without a consumed item");

  a_data_emits: assert property (@(posedge clk) disable iff (rst)
    take && !cls.is_end && state == ST_DATA |-> res_push && res.kind == KIND_DATA)
    else $error("payload byte not passed");

  a_idle_after_result: assert property (@(posedge clk) disable iff (rst)
    res_push && res.kind != KIND_DATA |=> state == ST_IDLE && remaining == '0)
    else $error("decoder not idle after message result");
`endif

endmodule
